// ===== src/psp_pkg.sv =====
// shared types, constants and divider step functions for the pixel sensor
// point-to-channel unit; no dependencies
package psp_pkg;

	localparam int MAX_CHIPS = 4;
	localparam int MAX_COLS  = 256;
	localparam int MAX_ROWS  = 256;
	localparam int CHIP_W    = $clog2(MAX_CHIPS);
	localparam int QW        = 28;
	localparam int DW        = 17;
	localparam int FW        = 16;

	localparam logic [2:0] REG_PIXEL_SIZE = 3'd0;
	localparam logic [2:0] REG_LONG_PIXEL = 3'd1;
	localparam logic [2:0] REG_CHIP_SIZE  = 3'd2;
	localparam logic [2:0] REG_CHIP_GAP   = 3'd3;
	localparam logic [2:0] REG_NUM_CHIPS  = 3'd4;
	localparam logic [2:0] REG_NUM_COLS   = 3'd5;
	localparam logic [2:0] REG_NUM_ROWS   = 3'd6;
	localparam logic [2:0] REG_SENSOR_ID  = 3'd7;

	typedef struct packed {
		logic [QW-1:0] a;
		logic [DW-1:0] r;
		logic [DW-1:0] d;
	} qlane_t;

	typedef struct packed {
		logic [DW-1:0] r;
		logic [DW-1:0] d;
		logic [FW-1:0] q;
		logic          sat;
	} flane_t;

	typedef struct packed {
		logic               in_area;
		logic               func;
		logic [CHIP_W-1:0]  chip;
		logic signed [28:0] x;
	} qtag_t;

	typedef struct packed {
		logic              in_area;
		logic [CHIP_W-1:0] chip;
		logic [7:0]        col;
		logic [7:0]        row;
	} ftag_t;

	function automatic qlane_t qr_step(input qlane_t l);
		qlane_t    o;
		logic [DW:0] t;
		o = l;
		t = {l.r, l.a[QW-1]};
		if (t >= {1'b0, l.d}) begin
			o.r = DW'(t - {1'b0, l.d});
			o.a = {l.a[QW-2:0], 1'b1};
		end else begin
			o.r = t[DW-1:0];
			o.a = {l.a[QW-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic flane_t fr_step(input flane_t l);
		flane_t    o;
		logic [DW:0] t;
		o = l;
		t = {l.r, 1'b0};
		if (t >= {1'b0, l.d}) begin
			o.r = DW'(t - {1'b0, l.d});
			o.q = {l.q[FW-2:0], 1'b1};
		end else begin
			o.r = t[DW-1:0];
			o.q = {l.q[FW-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

// ===== src/psp_qrdiv.sv =====
// pipelined restoring divider, one quotient bit per stage, column and row lanes
// depends on psp_pkg
module psp_qrdiv (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  psp_pkg::qtag_t  in_tag,
	input  psp_pkg::qlane_t in_c,
	input  psp_pkg::qlane_t in_r,
	output logic            out_vld,
	output psp_pkg::qtag_t  out_tag,
	output psp_pkg::qlane_t out_c,
	output psp_pkg::qlane_t out_r
);
	logic [psp_pkg::QW-1:0] vld_s;
	psp_pkg::qtag_t  tag_s [psp_pkg::QW];
	psp_pkg::qlane_t c_s   [psp_pkg::QW];
	psp_pkg::qlane_t r_s   [psp_pkg::QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[psp_pkg::QW-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= in_tag;
			c_s[0]   <= psp_pkg::qr_step(in_c);
			r_s[0]   <= psp_pkg::qr_step(in_r);
			for (int k = 1; k < psp_pkg::QW; k++) begin
				tag_s[k] <= tag_s[k-1];
				c_s[k]   <= psp_pkg::qr_step(c_s[k-1]);
				r_s[k]   <= psp_pkg::qr_step(r_s[k-1]);
			end
		end
	end

	assign out_vld = vld_s[psp_pkg::QW-1];
	assign out_tag = tag_s[psp_pkg::QW-1];
	assign out_c   = c_s[psp_pkg::QW-1];
	assign out_r   = r_s[psp_pkg::QW-1];
endmodule

// ===== src/psp_fracdiv.sv =====
// pipelined fraction divider, one fraction bit per stage, column and row lanes
// depends on psp_pkg
module psp_fracdiv (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  psp_pkg::ftag_t  in_tag,
	input  psp_pkg::flane_t in_c,
	input  psp_pkg::flane_t in_r,
	output logic            out_vld,
	output psp_pkg::ftag_t  out_tag,
	output psp_pkg::flane_t out_c,
	output psp_pkg::flane_t out_r
);
	logic [psp_pkg::FW-1:0] vld_s;
	psp_pkg::ftag_t  tag_s [psp_pkg::FW];
	psp_pkg::flane_t c_s   [psp_pkg::FW];
	psp_pkg::flane_t r_s   [psp_pkg::FW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[psp_pkg::FW-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= in_tag;
			c_s[0]   <= psp_pkg::fr_step(in_c);
			r_s[0]   <= psp_pkg::fr_step(in_r);
			for (int k = 1; k < psp_pkg::FW; k++) begin
				tag_s[k] <= tag_s[k-1];
				c_s[k]   <= psp_pkg::fr_step(c_s[k-1]);
				r_s[k]   <= psp_pkg::fr_step(r_s[k-1]);
			end
		end
	end

	assign out_vld = vld_s[psp_pkg::FW-1];
	assign out_tag = tag_s[psp_pkg::FW-1];
	assign out_c   = c_s[psp_pkg::FW-1];
	assign out_r   = r_s[psp_pkg::FW-1];
endmodule

// ===== src/pixel_sensor_point_to_channel_unit.sv =====
// top level of the pixel sensor point-to-channel unit: config registers,
// area and chip stages, output register; uses psp_pkg, psp_qrdiv, psp_fracdiv
//
// Maps a local point (x, y in 1/256 um) and a mode to chip, pixel column,
// pixel row and, in mode 1, 17-bit interpolation fractions with 16 fraction
// bits. One beat is taken per cycle while the output is not stalled. The
// pipeline is 49 register stages deep. The depth is set by three front
// stages, the 28-stage quotient divider (one bit per stage), one select
// stage, the 16-stage fraction divider and the output register. A stall on
// the output freezes the whole pipeline. Write registers only while idle.
module pixel_sensor_point_to_channel_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // func, local_x, local_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // in_area, sensor, chip, col, row, frac_col, frac_row
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	localparam int NM = psp_pkg::MAX_CHIPS;

	logic [15:0] pix_q, lpix_q;
	logic [23:0] csize_q;
	logic [19:0] gap_q;
	logic [2:0]  nchip_q;
	logic [8:0]  ncol_q, nrow_q;
	logic [7:0]  sid_q;

	logic [15:0] p_q, lp_q;
	logic [23:0] c_q;
	logic [2:0]  n_q;
	logic [8:0]  nc1_q, nr1_q;
	logic [16:0] twop_q, plp_q, twolp_q;
	logic [25:0] c2g_q;
	logic [27:0] sizex_q;
	logic [27:0] mul_q [NM+1];

	logic en;

	assign cfg_ready = 1'b1;
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q   <= 16'd14080;
			lpix_q  <= 16'd28160;
			csize_q <= 24'd3604480;
			gap_q   <= 20'd28160;
			nchip_q <= 3'd3;
			ncol_q  <= 9'd256;
			nrow_q  <= 9'd256;
			sid_q   <= 8'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				psp_pkg::REG_PIXEL_SIZE: pix_q   <= cfg_data[15:0];
				psp_pkg::REG_LONG_PIXEL: lpix_q  <= cfg_data[15:0];
				psp_pkg::REG_CHIP_SIZE:  csize_q <= cfg_data;
				psp_pkg::REG_CHIP_GAP:   gap_q   <= cfg_data[19:0];
				psp_pkg::REG_NUM_CHIPS:  nchip_q <= cfg_data[2:0];
				psp_pkg::REG_NUM_COLS:   ncol_q  <= cfg_data[8:0];
				psp_pkg::REG_NUM_ROWS:   nrow_q  <= cfg_data[8:0];
				psp_pkg::REG_SENSOR_ID:  sid_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// derived geometry
	logic [15:0] p_d, lp_d;
	logic [23:0] c_d;
	logic [2:0]  n_d;
	logic [8:0]  nc_d, nr_d;
	logic [24:0] step_d;

	always_comb begin
		p_d  = (pix_q == '0) ? 16'd1 : pix_q;
		lp_d = (lpix_q == '0) ? 16'd1 : lpix_q;
		c_d  = (csize_q == '0) ? 24'd1 : csize_q;
		if (nchip_q == '0) n_d = 3'd1;
		else if (nchip_q > 3'(NM)) n_d = 3'(NM);
		else n_d = nchip_q;
		if (ncol_q < 9'd2) nc_d = 9'd2;
		else if (ncol_q > 9'(psp_pkg::MAX_COLS)) nc_d = 9'(psp_pkg::MAX_COLS);
		else nc_d = ncol_q;
		if (nrow_q == '0) nr_d = 9'd1;
		else if (nrow_q > 9'(psp_pkg::MAX_ROWS)) nr_d = 9'(psp_pkg::MAX_ROWS);
		else nr_d = nrow_q;
		step_d = {1'b0, c_d} + {5'b0, gap_q};
	end

	always_ff @(posedge clk) begin
		p_q     <= p_d;
		lp_q    <= lp_d;
		c_q     <= c_d;
		n_q     <= n_d;
		nc1_q   <= nc_d - 9'd1;
		nr1_q   <= nr_d - 9'd1;
		twop_q  <= {p_d, 1'b0};
		twolp_q <= {lp_d, 1'b0};
		plp_q   <= {1'b0, p_d} + {1'b0, lp_d};
		c2g_q   <= {1'b0, c_d, 1'b0} + {6'b0, gap_q};
		sizex_q <= 28'({3'b0, step_d} * n_d) - {8'b0, gap_q};
		for (int k = 0; k <= NM; k++) begin
			mul_q[k] <= 28'({3'b0, step_d} * k);
		end
	end

	// stage 1: input register
	logic               vld_s1, func_s1;
	logic signed [26:0] px_s1, py_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= s_tdata[0];
			px_s1   <= s_tdata[27:1];
			py_s1   <= s_tdata[54:28];
		end
	end

	// stage 2: area check and chip search
	logic                        vld_s2, func_s2, area_s2;
	logic [psp_pkg::CHIP_W-1:0]  chip_s2;
	logic signed [26:0]          px_s2, py_s2;
	logic [psp_pkg::CHIP_W-1:0]  chip_d;
	logic                        area_d;
	logic signed [29:0]          pxe, diff;

	always_comb begin
		pxe    = 30'(px_s1);
		area_d = !px_s1[26] && !py_s1[26] && (pxe <= $signed({2'b0, sizex_q}))
			&& ({3'b0, py_s1[25:0]} <= {5'b0, c_q});
		chip_d = psp_pkg::CHIP_W'(n_q - 3'd1);
		diff   = '0;
		for (int k = NM - 1; k >= 0; k--) begin
			diff = pxe - $signed({2'b0, mul_q[k]});
			if (3'(k) < n_q) begin
				if (!func_s1) begin
					if ($signed({diff, 1'b0}) < $signed({5'b0, c2g_q}))
						chip_d = psp_pkg::CHIP_W'(k);
				end else if (pxe < $signed({2'b0, mul_q[k+1]})) begin
					chip_d = psp_pkg::CHIP_W'(k);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			area_s2 <= area_d;
			chip_s2 <= chip_d;
			px_s2   <= px_s1;
			py_s2   <= py_s1;
		end
	end

	// stage 3: position within the chip
	logic                       vld_s3, func_s3, area_s3;
	logic [psp_pkg::CHIP_W-1:0] chip_s3;
	logic signed [28:0]         x_s3;
	logic signed [26:0]         py_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s3 <= func_s2;
			area_s3 <= area_s2;
			chip_s3 <= chip_s2;
			x_s3    <= 29'(px_s2) - $signed({1'b0, mul_q[chip_s2]});
			py_s3   <= py_s2;
		end
	end

	// divider operands
	psp_pkg::qtag_t  qi_tag;
	psp_pkg::qlane_t qi_c, qi_r;
	logic signed [29:0] x2p, y2p;

	always_comb begin
		x2p = {x_s3, 1'b0} - $signed({14'b0, p_q});
		y2p = 30'({py_s3, 1'b0}) - $signed({14'b0, p_q});
		qi_tag.in_area = area_s3;
		qi_tag.func    = func_s3;
		qi_tag.chip    = chip_s3;
		qi_tag.x       = x_s3;
		qi_c.r = '0;
		qi_r.r = '0;
		if (func_s3) begin
			qi_c.a = (x2p > 0) ? x2p[27:0] : '0;
			qi_c.d = twop_q;
			qi_r.a = (y2p > 0) ? y2p[27:0] : '0;
			qi_r.d = twop_q;
		end else begin
			qi_c.a = (x_s3 > 0) ? x_s3[27:0] : '0;
			qi_c.d = {1'b0, p_q};
			qi_r.a = (py_s3 > 0) ? {1'b0, py_s3} : '0;
			qi_r.d = {1'b0, p_q};
		end
	end

	logic            qo_vld;
	psp_pkg::qtag_t  qo_tag;
	psp_pkg::qlane_t qo_c, qo_r;

	psp_qrdiv u_qrdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s3),
		.in_tag  (qi_tag),
		.in_c    (qi_c),
		.in_r    (qi_r),
		.out_vld (qo_vld),
		.out_tag (qo_tag),
		.out_c   (qo_c),
		.out_r   (qo_r)
	);

	// stage 4: column and row selection, fraction operands
	logic                       vld_s4, area_s4, rsat_s4;
	logic [psp_pkg::CHIP_W-1:0] chip_s4;
	logic [7:0]                 col_s4, row_s4;
	logic signed [29:0]         numc_s4, numr_s4;
	logic [16:0]                denc_s4;
	logic [7:0]                 col_d, row_d;
	logic signed [29:0]         numc_d, numr_d, rem_c, x2;
	logic [16:0]                denc_d;
	logic                       rsat_d, first, last, bigc, bigr;

	always_comb begin
		first  = qo_tag.chip == '0;
		last   = {1'b0, qo_tag.chip} == n_q - 3'd1;
		bigc   = qo_c.a >= {19'b0, nc1_q};
		bigr   = qo_r.a > {19'b0, nr1_q};
		rem_c  = $signed({13'b0, qo_c.r});
		x2     = {qo_tag.x, 1'b0};
		numc_d = '0;
		denc_d = twop_q;
		numr_d = '0;
		rsat_d = 1'b0;
		if (bigr) row_d = nr1_q[7:0];
		else row_d = qo_r.a[7:0];
		if (!qo_tag.func) begin
			col_d = bigc ? nc1_q[7:0] : qo_c.a[7:0];
		end else begin
			numr_d = $signed({13'b0, qo_r.r});
			rsat_d = bigr;
			if (qo_c.a == '0) begin
				col_d = '0;
				if (first) begin
					numc_d = rem_c;
				end else begin
					numc_d = x2;
					denc_d = plp_q;
				end
			end else if (bigc) begin
				col_d = nc1_q[7:0];
				if (last) begin
					numc_d = rem_c;
				end else if (qo_tag.x < $signed({5'b0, c_q})) begin
					col_d  = 8'(nc1_q - 9'd1);
					numc_d = x2 + $signed({13'b0, plp_q}) - $signed({5'b0, c_q, 1'b0});
					denc_d = plp_q;
				end else begin
					numc_d = 30'(qo_tag.x) - $signed({6'b0, c_q});
					denc_d = {1'b0, lp_q};
				end
			end else begin
				col_d  = qo_c.a[7:0];
				numc_d = rem_c;
				if ({1'b0, qo_c.a[7:0]} == nc1_q - 9'd1 && !last) denc_d = twolp_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= qo_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			area_s4 <= qo_tag.in_area;
			chip_s4 <= qo_tag.chip;
			col_s4  <= col_d;
			row_s4  <= row_d;
			numc_s4 <= numc_d;
			denc_s4 <= denc_d;
			numr_s4 <= numr_d;
			rsat_s4 <= rsat_d;
		end
	end

	function automatic psp_pkg::flane_t fprep(input logic signed [29:0] num,
		input logic [16:0] den, input logic force_sat);
		psp_pkg::flane_t l;
		logic            pos;
		pos   = num > 0;
		l.sat = force_sat || (pos && num >= $signed({13'b0, den}));
		l.r   = (pos && !l.sat) ? num[16:0] : '0;
		l.d   = den;
		l.q   = '0;
		return l;
	endfunction

	psp_pkg::ftag_t  fi_tag;
	psp_pkg::flane_t fi_c, fi_r;

	always_comb begin
		fi_tag.in_area = area_s4;
		fi_tag.chip    = chip_s4;
		fi_tag.col     = col_s4;
		fi_tag.row     = row_s4;
		fi_c = fprep(numc_s4, denc_s4, 1'b0);
		fi_r = fprep(numr_s4, twop_q, rsat_s4);
	end

	logic            fo_vld;
	psp_pkg::ftag_t  fo_tag;
	psp_pkg::flane_t fo_c, fo_r;

	psp_fracdiv u_fracdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s4),
		.in_tag  (fi_tag),
		.in_c    (fi_c),
		.in_r    (fi_r),
		.out_vld (fo_vld),
		.out_tag (fo_tag),
		.out_c   (fo_c),
		.out_r   (fo_r)
	);

	// output register
	logic        out_vld_q;
	logic [63:0] out_data_q;
	logic [16:0] fc, fr;

	always_comb begin
		fc = fo_c.sat ? 17'h10000 : {1'b0, fo_c.q};
		fr = fo_r.sat ? 17'h10000 : {1'b0, fo_r.q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= fo_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fo_tag.in_area) begin
				out_data_q <= {3'b0, fr, fc, fo_tag.row, fo_tag.col, fo_tag.chip, sid_q, 1'b1};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata == '0)
		else $error("outside point with nonzero fields");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[43:27] <= 17'h10000 && m_tdata[60:44] <= 17'h10000)
		else $error("fraction above one");

	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s1 |=> vld_s2)
		else $error("beat lost between first stages");
endmodule

// ===== tb/pixel_map_checker.sv =====
`timescale 1ns / 1ps
// checker for the pixel sensor point-to-channel unit: watches the point, hit and
// register channels, predicts each hit and compares it; uses psp_pkg constants only
module pixel_map_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          mismatches,
	output int          hits_due
);
	typedef struct packed {
		bit        in_area;
		bit [7:0]  sensor;
		bit [1:0]  chip;
		bit [7:0]  col;
		bit [7:0]  row;
		bit [16:0] frac_col;
		bit [16:0] frac_row;
	} pixel_hit_t;

	localparam int ONE16 = 65536;

	bit [23:0]  geom [8];
	pixel_hit_t hit_queue[$];

	function automatic bit [23:0] reg_mask(input logic [2:0] idx, input logic [23:0] v);
		case (idx)
			psp_pkg::REG_PIXEL_SIZE, psp_pkg::REG_LONG_PIXEL: return v & 24'hFFFF;
			psp_pkg::REG_CHIP_SIZE:  return v;
			psp_pkg::REG_CHIP_GAP:   return v & 24'hFFFFF;
			psp_pkg::REG_NUM_CHIPS:  return v & 24'h7;
			psp_pkg::REG_NUM_COLS, psp_pkg::REG_NUM_ROWS: return v & 24'h1FF;
			default:        return v & 24'hFF;
		endcase
	endfunction

	function automatic longint bound(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic bit [16:0] ratio16(input longint num, input longint den);
		longint q;
		if (num <= 0) return 0;
		q = (num * ONE16) / den;
		if (q > ONE16) q = ONE16;
		return q[16:0];
	endfunction

	function automatic pixel_hit_t map_point(input logic [55:0] beat);
		pixel_hit_t h;
		longint p, lp, c, g, n, nc, nr, px, py, pitch, size_x, chip, x, col, row;
		longint twop, num, icol, rem, rnum;
		bit        mode, found;
		bit [16:0] fc, fr;
		p  = geom[psp_pkg::REG_PIXEL_SIZE] ? longint'(geom[psp_pkg::REG_PIXEL_SIZE]) : 1;
		lp = geom[psp_pkg::REG_LONG_PIXEL] ? longint'(geom[psp_pkg::REG_LONG_PIXEL]) : 1;
		c  = geom[psp_pkg::REG_CHIP_SIZE] ? longint'(geom[psp_pkg::REG_CHIP_SIZE]) : 1;
		g  = geom[psp_pkg::REG_CHIP_GAP];
		n  = bound(geom[psp_pkg::REG_NUM_CHIPS], 1, psp_pkg::MAX_CHIPS);
		nc = bound(geom[psp_pkg::REG_NUM_COLS], 2, psp_pkg::MAX_COLS);
		nr = bound(geom[psp_pkg::REG_NUM_ROWS], 1, psp_pkg::MAX_ROWS);
		mode = beat[0];
		px = longint'($signed(beat[27:1]));
		py = longint'($signed(beat[54:28]));
		pitch = c + g;
		size_x = n * c + (n - 1) * g;
		twop = 2 * p;
		col = 0;
		row = 0;
		fc = 0;
		fr = 0;
		h = '{default: 0};
		if (px < 0 || px > size_x || py < 0 || py > c) return h;
		chip = n - 1;
		found = 0;
		for (longint k = 0; k < n; k++) begin
			if (!found) begin
				if (mode == 0) begin
					if (2 * (px - k * pitch) < 2 * c + g) begin
						chip = k;
						found = 1;
					end
				end else if (px < (k + 1) * pitch) begin
					chip = k;
					found = 1;
				end
			end
		end
		x = px - chip * pitch;
		if (mode == 0) begin
			if (x > 0) col = x / p;
			if (col > nc - 1) col = nc - 1;
			if (py > 0) row = py / p;
			if (row > nr - 1) row = nr - 1;
		end else begin
			num = 2 * x - p;
			icol = (num > 0) ? num / twop : 0;
			rem = (num > 0) ? num - icol * twop : 0;
			rnum = 2 * py - p;
			if (icol == 0) begin
				col = 0;
				fc = (chip == 0) ? ratio16(rem, twop) : ratio16(2 * x, p + lp);
			end else if (icol >= nc - 1) begin
				col = nc - 1;
				if (chip == n - 1) begin
					fc = ratio16(rem, twop);
				end else if (x < c) begin
					col = nc - 2;
					fc = ratio16(p + lp - 2 * (c - x), p + lp);
				end else begin
					fc = ratio16(x - c, lp);
				end
			end else begin
				col = icol;
				fc = (icol == nc - 2 && chip < n - 1) ? ratio16(rem, 2 * lp) : ratio16(rem, twop);
			end
			if (rnum > 0) begin
				row = rnum / twop;
				fr = ratio16(rnum - row * twop, twop);
			end
			if (row > nr - 1) begin
				row = nr - 1;
				fr = ONE16;
			end
		end
		h.in_area = 1;
		h.sensor = geom[psp_pkg::REG_SENSOR_ID][7:0];
		h.chip = chip[1:0];
		h.col = col[7:0];
		h.row = row[7:0];
		h.frac_col = fc;
		h.frac_row = fr;
		return h;
	endfunction

	function automatic pixel_hit_t unpack_hit(input logic [63:0] d);
		pixel_hit_t h;
		h.in_area = d[0];
		h.sensor = d[8:1];
		h.chip = d[10:9];
		h.col = d[18:11];
		h.row = d[26:19];
		h.frac_col = d[43:27];
		h.frac_row = d[60:44];
		return h;
	endfunction

	assign hits_due = hit_queue.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_hit_t got, want;
		if (!arst_n) begin
			geom = '{24'd14080, 24'd28160, 24'd3604480, 24'd28160, 24'd3, 24'd256,
				24'd256, 24'd0};
			hit_queue.delete();
			mismatches <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				geom[cfg_index] = reg_mask(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				hit_queue.push_back(map_point(s_tdata));
			if (m_tvalid && m_tready) begin
				got = unpack_hit(m_tdata);
				if (hit_queue.size() == 0) begin
					if (mismatches < 10)
						$display("%t unexpected hit beat %h", $realtime, m_tdata);
					mismatches <= mismatches + 1;
				end else begin
					want = hit_queue.pop_front();
					if (got != want || m_tdata[63:61] != 0) begin
						if (mismatches < 10)
							$display({"%t hit: exp area %0d sen %0d chip %0d col %0d row %0d",
								" fc %0d fr %0d / got %0d %0d %0d %0d %0d %0d %0d"},
								$realtime, want.in_area, want.sensor, want.chip, want.col,
								want.row, want.frac_col, want.frac_row, got.in_area,
								got.sensor, got.chip, got.col, got.row, got.frac_col,
								got.frac_row);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

// ===== tb/pixel_sensor_point_to_channel_unit_test.sv =====
`timescale 1ns / 1ps
// testbench top for the pixel sensor point-to-channel unit: drives points and
// register writes, gives the verdict; uses psp_pkg, pixel_map_checker and the unit
module pixel_sensor_point_to_channel_unit_test;
	localparam int STALL_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;
	bit          steady = 1'b0;
	int          mismatches, hits_due, quiet_cycles;
	longint      geom [8] = '{14080, 28160, 3604480, 28160, 3, 256, 256, 0};

	pixel_sensor_point_to_channel_unit i_dut (.*);

	pixel_map_checker i_checker (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk)
		m_tready <= steady || ($urandom_range(0, 99) >= 32);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_point(input bit mode, input longint x, input longint y);
		bit ok;
		while (!steady && $urandom_range(0, 99) < 32) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, y[26:0], x[26:0], mode};
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
	endtask

	// valid stays high between writes; the caller drops it after the last one
	task automatic write_reg(input logic [2:0] idx, input longint v);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[23:0];
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		geom[idx] = v;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (hits_due != 0) @(posedge clk);
	endtask

	// corners, outside by one, gap edges and the border between chips
	task automatic send_edges;
		longint c, g, n, sx;
		c = geom[psp_pkg::REG_CHIP_SIZE] ? geom[psp_pkg::REG_CHIP_SIZE] : 1;
		g = geom[psp_pkg::REG_CHIP_GAP];
		n = geom[psp_pkg::REG_NUM_CHIPS];
		n = (n < 1) ? 1 : ((n > 4) ? 4 : n);
		sx = n * c + (n - 1) * g;
		for (int m = 0; m < 2; m++) begin
			send_point(m, 0, 0);
			send_point(m, sx, c);
			send_point(m, sx + 1, 0);
			send_point(m, -1, c);
			send_point(m, 0, c + 1);
			send_point(m, c + g / 2, 1);
			send_point(m, c - 1, c - 1);
			send_point(m, c + g, c / 2);
		end
	endtask

	task automatic send_random(input int count);
		longint c, g, n, sx, x, y, k;
		c = geom[psp_pkg::REG_CHIP_SIZE] ? geom[psp_pkg::REG_CHIP_SIZE] : 1;
		g = geom[psp_pkg::REG_CHIP_GAP];
		n = geom[psp_pkg::REG_NUM_CHIPS];
		n = (n < 1) ? 1 : ((n > 4) ? 4 : n);
		sx = n * c + (n - 1) * g;
		if (sx > 67108863) sx = 67108863;
		repeat (count) begin
			case ($urandom_range(0, 9))
				0: begin
					x = longint'($signed(27'($urandom)));
					y = longint'($signed(27'($urandom)));
				end
				1, 2: begin
					k = $urandom_range(0, n - 1);
					x = k * (c + g) + c - 3 + $urandom_range(0, g + 6);
					y = longint'($urandom_range(0, c + 2)) - 1;
				end
				default: begin
					x = longint'($urandom_range(0, sx + 4)) - 2;
					y = longint'($urandom_range(0, c + 2)) - 1;
				end
			endcase
			send_point($urandom_range(0, 1), x, y);
		end
	endtask

	task automatic run_setting(input longint v [8], input int count);
		drain();
		for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
		cfg_valid <= 1'b0;
		send_edges();
		send_random(count);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_point(0, 67108863, 67108863);
		send_point(1, -67108864, -67108864);
		send_point(1, 7040, 7040);
		send_point(1, 7039, 7041);
		send_point(1, 3604480 - 1000, 20000);
		send_point(1, 3604480 + 14000, 20000);
		send_point(0, 3604480 + 14079, 5);
		send_point(0, 3604480 + 14080, 5);
		send_point(1, 3632640 + 3000, 3604480);
		send_point(1, 3632640 - 1, 3604479);
		send_edges();

		run_setting('{256, 512, 4096, 0, 4, 16, 16, 165}, 87);
		run_setting('{0, 0, 0, 0, 0, 0, 0, 255}, 87);
		run_setting('{65535, 65535, 16777215, 1048575, 7, 511, 511, 0}, 87);
		run_setting('{1000, 1500, 40000, 3000, 2, 40, 7, 90}, 87);
		run_setting('{100, 37, 777, 55, 1, 2, 1, 60}, 87);
		run_setting('{14080, 28160, 3604480, 28160, 3, 256, 256, 17}, 87);
		steady = 1'b1;
		run_setting('{300, 700, 9000, 100, 5, 257, 300, 1}, 87);
		steady = 1'b0;

		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && hits_due == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/psp_pkg.sv
src/psp_qrdiv.sv
src/psp_fracdiv.sv
src/pixel_sensor_point_to_channel_unit.sv
tb/pixel_map_checker.sv
tb/pixel_sensor_point_to_channel_unit_test.sv
